>>> hdl/wfe_pkg.sv
// wfe_pkg: shared types and constants for the wireframe edge quad expander
// holds the transfer payload structs, the sequencer state type and fixed widths
// no dependencies
package wfe_pkg;

  localparam int unsigned THICK_W     = 23;
  localparam int unsigned COORD_W     = 32;
  localparam logic [THICK_W-1:0] THICK_RESET = 23'd65536;

  // square root yields one result bit per step, division one quotient bit per step
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned DIV_STEPS  = THICK_W;

  typedef struct packed {
    logic signed [COORD_W-1:0] vert_x;
    logic signed [COORD_W-1:0] vert_y;
    logic signed [COORD_W-1:0] vert_z;
    logic signed [COORD_W-1:0] normal_z;
    logic                      starts_polygon;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic                      end_of_strip;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MAG,
    ST_MAX,
    ST_NORM,
    ST_SQ,
    ST_SQRT,
    ST_MUL,
    ST_ADD,
    ST_DIV,
    ST_OFFS,
    ST_EMIT
  } state_t;

endpackage

>>> hdl/wireframe_edge_quad_expander.sv
// wireframe_edge_quad_expander: turns polygon edges into four-vertex line strips
// depends on wfe_pkg for payload structs, state type and widths
//
// Vertices stream in one per input transfer. The block holds the previous vertex
// and, for every vertex after the first of a front-facing polygon (normal_z
// negative), emits four strip vertices P-o, P+o, C-o, C+o where o is the edge
// perpendicular from the 3D unit difference scaled by half of line_thickness;
// the closing edge of a polygon is not drawn. A vertex that draws nothing is
// taken without stalling the input. A vertex that draws an edge keeps the input
// stalled, also through any output stall, while the block steps through
// difference and magnitude setup, normalization (up to four bit positions per
// cycle), the shared squarer, bit-serial square root, then twice through the
// shared multiplier and the restoring divider (one quotient bit per cycle),
// signing of the offsets and loading of the strip vertices, one per cycle while
// the output is not stalled, into the output register. A zero-length edge skips
// the arithmetic and goes straight to loading its strip vertices. The last strip
// vertex may still sit in the output register while the next vertex is taken.
// The user must write line_thickness only while the block is idle; the block
// itself does not enforce this.
module wireframe_edge_quad_expander (
  input  logic                       clk,
  input  logic                       rst_n,
  // input vertex channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  wfe_pkg::in_item_t          in_data,
  // strip vertex channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output wfe_pkg::out_item_t         out_data,
  // configuration write port
  input  logic                       cfg_wr_en,
  input  logic [wfe_pkg::THICK_W-1:0] cfg_wr_data
);
  import wfe_pkg::*;

  // sequencer
  state_t state_r, state_nxt;
  logic [4:0] cnt_r;
  logic [1:0] idx_r;
  logic       sel_r;       // 0: y offset division, 1: x offset division

  // architectural state
  logic [THICK_W-1:0]        thick_r;
  logic signed [COORD_W-1:0] prev_x_r, prev_y_r, prev_z_r;
  logic                      have_prev_r;

  // current vertex of the edge being expanded
  logic signed [COORD_W-1:0] cur_x_r, cur_y_r, cur_z_r;

  // datapath registers
  logic signed [COORD_W:0] d_x_r, d_y_r, d_z_r;
  logic [COORD_W:0]        mag_x_r, mag_y_r, mag_z_r;
  logic [COORD_W:0]        m_r;
  logic [61:0]             prod_r;
  logic [63:0]             sum_r;
  logic [32:0]             rem_r;
  logic [31:0]             root_r;
  logic [54:0]             num_r;
  logic [32:0]             drem_r;
  logic [THICK_W-1:0]      quot_r;
  logic [THICK_W-1:0]      ax_r, ay_r;
  logic signed [THICK_W:0] ox_r, oy_r;

  // output register
  logic      out_valid_r;
  out_item_t out_data_r;

  // handshake strobes
  logic accept;
  logic draw;
  logic out_load;

  // combinational datapath
  logic [COORD_W:0] max_c;
  logic [30:0]      sq_op;
  logic [34:0]      sq_rem_sh;
  logic [34:0]      sq_trial;
  logic             sq_ge;
  logic [30:0]      mul_op;
  logic [53:0]      mul_prod;
  logic [54:0]      num_sum;
  logic [33:0]      div_sh;
  logic [33:0]      div_dvs;
  logic             div_ge;
  logic signed [33:0] base_x, base_y, off_x, off_y, sum_x, sum_y;
  out_item_t        emit_item;

  function automatic logic [COORD_W:0] mag_of(input logic signed [COORD_W:0] v);
    mag_of = v[COORD_W] ? (~v + (COORD_W+1)'(1)) : v;
  endfunction

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [33:0] v);
    logic signed [COORD_W-1:0] r;
    if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
      r = v[31:0];
    end else if (v[33]) begin
      r = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(COORD_W-1){1'b1}}};
    end
    sat32 = r;
  endfunction

  // ---------------------------------------------------------------------------
  // handshake and strobes
  // ---------------------------------------------------------------------------
  always_comb begin
    in_stall = (state_r != ST_IDLE);
    accept   = in_valid && !in_stall;
    draw     = !in_data.starts_polygon && have_prev_r && in_data.normal_z[COORD_W-1];
    out_load = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------------
  // shared arithmetic
  // ---------------------------------------------------------------------------
  always_comb begin
    // largest of the three magnitudes
    max_c = mag_x_r;
    if (mag_y_r > max_c) begin
      max_c = mag_y_r;
    end
    if (mag_z_r > max_c) begin
      max_c = mag_z_r;
    end

    // squarer operand, one magnitude per cycle
    case (cnt_r[1:0])
      2'd0:    sq_op = mag_x_r[30:0];
      2'd1:    sq_op = mag_y_r[30:0];
      2'd2:    sq_op = mag_z_r[30:0];
      default: sq_op = '0;
    endcase

    // square root step: bring down two radicand bits, try root*4+1
    sq_rem_sh = {rem_r, sum_r[63:62]};
    sq_trial  = {1'b0, root_r, 2'b01};
    sq_ge     = (sq_rem_sh >= sq_trial);

    // multiplier operand for the offset numerator
    mul_op   = sel_r ? mag_x_r[30:0] : mag_y_r[30:0];
    mul_prod = 54'(mul_op) * 54'(thick_r);
    num_sum  = num_r + {23'd0, root_r};

    // restoring division by twice the length
    div_sh  = {drem_r, num_r[DIV_STEPS-1]};
    div_dvs = {1'b0, root_r, 1'b0};
    div_ge  = (div_sh >= div_dvs);

    // strip vertex: even index subtracts the offset, odd adds; upper half uses C
    base_x = idx_r[1] ? 34'(cur_x_r) : 34'(prev_x_r);
    base_y = idx_r[1] ? 34'(cur_y_r) : 34'(prev_y_r);
    off_x  = 34'(ox_r);
    off_y  = 34'(oy_r);
    sum_x  = idx_r[0] ? (base_x + off_x) : (base_x - off_x);
    sum_y  = idx_r[0] ? (base_y + off_y) : (base_y - off_y);
    emit_item.out_x        = sat32(sum_x);
    emit_item.out_y        = sat32(sum_y);
    emit_item.out_z        = idx_r[1] ? cur_z_r : prev_z_r;
    emit_item.end_of_strip = (idx_r == 2'd3);
  end

  // ---------------------------------------------------------------------------
  // next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && draw) begin
          state_nxt = ST_DIFF;
        end
      end
      ST_DIFF: state_nxt = ST_MAG;
      ST_MAG:  state_nxt = ST_MAX;
      ST_MAX: begin
        // zero-length edge: no normalization, offsets stay zero
        state_nxt = (max_c == '0) ? ST_EMIT : ST_NORM;
      end
      ST_NORM: begin
        if (m_r[COORD_W:31] == '0 && m_r[30]) begin
          state_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        if (cnt_r == 5'd3) begin
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (cnt_r == 5'(SQRT_STEPS - 1)) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: state_nxt = ST_ADD;
      ST_ADD: state_nxt = ST_DIV;
      ST_DIV: begin
        if (cnt_r == 5'(DIV_STEPS - 1)) begin
          state_nxt = sel_r ? ST_OFFS : ST_MUL;
        end
      end
      ST_OFFS: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_load && idx_r == 2'd3) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      sel_r       <= 1'b0;
      thick_r     <= THICK_RESET;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      prev_z_r    <= '0;
      have_prev_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_wr_en) begin
        thick_r <= cfg_wr_data;
      end

      // step counter restarts on every state change
      if (state_nxt != state_r) begin
        cnt_r <= '0;
      end else begin
        cnt_r <= cnt_r + 5'd1;
      end

      if (state_r == ST_MAX) begin
        sel_r <= 1'b0;
      end else if (state_r == ST_DIV && cnt_r == 5'(DIV_STEPS - 1)) begin
        sel_r <= 1'b1;
      end

      // a vertex that draws nothing is stored at once, an edge's end after its strip
      if (accept && !draw) begin
        prev_x_r    <= in_data.vert_x;
        prev_y_r    <= in_data.vert_y;
        prev_z_r    <= in_data.vert_z;
        have_prev_r <= 1'b1;
      end else if (out_load && idx_r == 2'd3) begin
        prev_x_r <= cur_x_r;
        prev_y_r <= cur_y_r;
        prev_z_r <= cur_z_r;
      end

      if (state_r == ST_IDLE) begin
        idx_r <= '0;
      end else if (out_load) begin
        idx_r <= idx_r + 2'd1;
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept && draw) begin
      cur_x_r <= in_data.vert_x;
      cur_y_r <= in_data.vert_y;
      cur_z_r <= in_data.vert_z;
    end

    if (out_load) begin
      out_data_r <= emit_item;
    end

    case (state_r)
      ST_DIFF: begin
        d_x_r <= 33'(prev_x_r) - 33'(cur_x_r);
        d_y_r <= 33'(prev_y_r) - 33'(cur_y_r);
        d_z_r <= 33'(prev_z_r) - 33'(cur_z_r);
      end
      ST_MAG: begin
        mag_x_r <= mag_of(d_x_r);
        mag_y_r <= mag_of(d_y_r);
        mag_z_r <= mag_of(d_z_r);
      end
      ST_MAX: begin
        m_r    <= max_c;
        prod_r <= '0;
        sum_r  <= '0;
        rem_r  <= '0;
        root_r <= '0;
        ox_r   <= '0;
        oy_r   <= '0;
      end
      ST_NORM: begin
        // bring the largest magnitude into [2^30, 2^31); right shifts truncate
        if (m_r[COORD_W:31] != '0) begin
          m_r     <= m_r >> 1;
          mag_x_r <= mag_x_r >> 1;
          mag_y_r <= mag_y_r >> 1;
          mag_z_r <= mag_z_r >> 1;
        end else if (m_r[30:26] == '0) begin
          m_r     <= m_r << 4;
          mag_x_r <= mag_x_r << 4;
          mag_y_r <= mag_y_r << 4;
          mag_z_r <= mag_z_r << 4;
        end else if (!m_r[30]) begin
          m_r     <= m_r << 1;
          mag_x_r <= mag_x_r << 1;
          mag_y_r <= mag_y_r << 1;
          mag_z_r <= mag_z_r << 1;
        end
      end
      ST_SQ: begin
        // squarer output registered, accumulated in the next cycle
        prod_r <= 62'(sq_op) * 62'(sq_op);
        sum_r  <= sum_r + {2'b00, prod_r};
      end
      ST_SQRT: begin
        sum_r <= sum_r << 2;
        if (sq_ge) begin
          rem_r  <= 33'(sq_rem_sh - sq_trial);
          root_r <= {root_r[30:0], 1'b1};
        end else begin
          rem_r  <= sq_rem_sh[32:0];
          root_r <= {root_r[30:0], 1'b0};
        end
      end
      ST_MUL: begin
        num_r <= {1'b0, mul_prod};
      end
      ST_ADD: begin
        // rounding term, then seed the remainder with the bits above the quotient
        num_r  <= num_sum;
        drem_r <= {1'b0, num_sum[54:DIV_STEPS]};
      end
      ST_DIV: begin
        num_r  <= num_r << 1;
        quot_r <= {quot_r[THICK_W-2:0], div_ge};
        if (div_ge) begin
          drem_r <= 33'(div_sh - div_dvs);
        end else begin
          drem_r <= div_sh[32:0];
        end
        if (cnt_r == 5'(DIV_STEPS - 1)) begin
          if (sel_r) begin
            ax_r <= {quot_r[THICK_W-2:0], div_ge};
          end else begin
            ay_r <= {quot_r[THICK_W-2:0], div_ge};
          end
        end
      end
      ST_OFFS: begin
        // perpendicular (-uy, ux) of the difference P - C
        ox_r <= d_y_r[COORD_W] ? $signed({1'b0, ay_r}) : -$signed({1'b0, ay_r});
        oy_r <= d_x_r[COORD_W] ? -$signed({1'b0, ax_r}) : $signed({1'b0, ax_r});
      end
      default: begin
      end
    endcase
  end

endmodule
